FILE: src/awt_pkg.sv
// Shared types and constants for the ARQ sender window tracker.
// No dependencies; used by the tracker unit and its testbench.
package awt_pkg;

   localparam int TIME_BITS      = 48;
   localparam int TOTAL_W        = 13;
   localparam int WINDOW_W       = 6;
   localparam int TIMEOUT_W      = 24;
   localparam int LIMIT_W        = 8;
   localparam int SEQ_W          = 12;
   localparam int ACK_W          = 32;
   localparam int CSR_DATA_W     = 24;
   localparam int CSR_INDEX_W    = 2;

   localparam int MAX_CHUNKS_DEF = 4096;
   localparam int MAX_WINDOW_DEF = 32;

   localparam logic [TOTAL_W-1:0]   TOTAL_RST   = 13'd0;
   localparam logic [WINDOW_W-1:0]  WINDOW_RST  = 6'd8;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd200000;
   localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 8'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK_TOTAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SIZE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_US  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_LIMIT = 2'd3;

   localparam logic REQ_POLL = 1'b0;
   localparam logic REQ_ACK  = 1'b1;

   localparam logic [1:0] KIND_SEND   = 2'd0;
   localparam logic [1:0] KIND_RETX   = 2'd1;
   localparam logic [1:0] KIND_RTT    = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   typedef struct packed {
      logic                 req_type;
      logic [TIME_BITS-1:0] now_us;
      logic [ACK_W-1:0]     ack_seq;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [SEQ_W-1:0]     seq;
      logic [LIMIT_W-1:0]   attempt;
      logic [TIME_BITS-1:0] rtt_us;
      logic                 done_res;
      logic                 aborted;
      logic                 last;
   } rsp_payload_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] send_time;
      logic [LIMIT_W-1:0]   retries;
      logic                 acked;
      logic                 resent;
   } entry_type;

endpackage

FILE: src/awt_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
// Payload type comes from awt_pkg at instantiation.
interface awt_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/arq_sender_window_tracker_unit.sv
// Selective-repeat ARQ sender window tracker; per-chunk state in one synchronous RAM.
// Depends on awt_pkg and awt_chan_if.
// Ack: range check, RAM read, update, status. Poll: issue new sends, then scan the issued
// entries through the RAM read port, then status. Output backpressure can stall the steps
// that emit results; a new request is taken only in idle. Reset is synchronous; entries
// count as issued below next_issue, so the RAM needs no clearing pass.
module arq_sender_window_tracker_unit #(
   parameter int MAX_CHUNKS = awt_pkg::MAX_CHUNKS_DEF,
   parameter int MAX_WINDOW = awt_pkg::MAX_WINDOW_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   awt_chan_if.sink                           req_if,
   awt_chan_if.source                         rsp_if,
   input  logic                               csr_we,
   input  logic [awt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [awt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int CW0 = $clog2(MAX_CHUNKS + 1);
   localparam int CW  = (CW0 > awt_pkg::TOTAL_W) ? CW0 : awt_pkg::TOTAL_W;
   localparam int FW  = $clog2(MAX_WINDOW + 1);
   localparam logic [CW-1:0] MAX_CHUNKS_C = CW'(MAX_CHUNKS);
   localparam logic [FW-1:0] MAX_WINDOW_C = FW'(MAX_WINDOW);
   localparam int TB = awt_pkg::TIME_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ISSUE, ST_SCAN, ST_ACK_RD, ST_ACK_EV, ST_STATUS
   } state_type;

   state_type state_ff, state_in;

   logic [awt_pkg::TOTAL_W-1:0]   cfg_total_ff;
   logic [awt_pkg::WINDOW_W-1:0]  cfg_window_ff;
   logic [awt_pkg::TIMEOUT_W-1:0] cfg_timeout_ff;
   logic [awt_pkg::LIMIT_W-1:0]   cfg_limit_ff;

   awt_pkg::req_payload_type req_ff;
   awt_pkg::rsp_payload_type rsp_pl_ff, emit_pl;
   logic                     rsp_valid_ff, emit, out_free;

   logic [CW-1:0] next_issue_ff, next_issue_in;
   logic [FW-1:0] flight_ff, flight_in;
   logic [FW-1:0] n_ff, n_in;
   logic          abort_ff, abort_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          ev_vld_ff, ev_vld_in;
   logic [AW-1:0] ev_idx_ff, ev_idx_in;

   awt_pkg::entry_type mem [MAX_CHUNKS];
   awt_pkg::entry_type rd_data_ff, mem_wdata;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;

   logic [CW-1:0]                 eff_total;
   logic [awt_pkg::WINDOW_W-1:0]  eff_win;
   logic [awt_pkg::TIMEOUT_W-1:0] eff_tmo;
   logic [TB-1:0]                 delta;
   logic                          expired;

   always_comb begin
      if (CW'(cfg_total_ff) > MAX_CHUNKS_C) begin
         eff_total = MAX_CHUNKS_C;
      end else begin
         eff_total = CW'(cfg_total_ff);
      end
      if (cfg_window_ff == '0) begin
         eff_win = awt_pkg::WINDOW_W'(1);
      end else if (cfg_window_ff > awt_pkg::WINDOW_W'(MAX_WINDOW)) begin
         eff_win = awt_pkg::WINDOW_W'(MAX_WINDOW);
      end else begin
         eff_win = cfg_window_ff;
      end
      eff_tmo = (cfg_timeout_ff == '0) ? awt_pkg::TIMEOUT_W'(1) : cfg_timeout_ff;
      delta   = req_ff.now_us - rd_data_ff.send_time;
      expired = delta >= TB'(eff_tmo);
   end

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.payload = rsp_pl_ff;

   always_comb begin
      state_in      = state_ff;
      next_issue_in = next_issue_ff;
      flight_in     = flight_ff;
      n_in          = n_ff;
      abort_in      = abort_ff;
      rd_idx_in     = rd_idx_ff;
      ev_vld_in     = ev_vld_ff;
      ev_idx_in     = ev_idx_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      emit          = 1'b0;
      emit_pl       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               n_in = '0;
               if (abort_ff) begin
                  state_in = ST_STATUS;
               end else if (req_if.payload.req_type == awt_pkg::REQ_ACK) begin
                  state_in = ST_ACK_RD;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            if (next_issue_ff < eff_total && awt_pkg::WINDOW_W'(flight_ff) < eff_win &&
                n_ff < MAX_WINDOW_C) begin
               if (out_free) begin
                  emit                = 1'b1;
                  emit_pl.kind        = awt_pkg::KIND_SEND;
                  emit_pl.seq         = awt_pkg::SEQ_W'(next_issue_ff);
                  mem_we              = 1'b1;
                  mem_waddr           = next_issue_ff[AW-1:0];
                  mem_wdata.send_time = req_ff.now_us;
                  next_issue_in       = next_issue_ff + CW'(1);
                  flight_in           = flight_ff + FW'(1);
                  n_in                = n_ff + FW'(1);
               end
            end else begin
               state_in  = ST_SCAN;
               rd_idx_in = '0;
               ev_vld_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (ev_vld_ff && !rd_data_ff.acked && expired &&
                rd_data_ff.retries >= cfg_limit_ff) begin
               abort_in  = 1'b1;
               ev_vld_in = 1'b0;
               state_in  = ST_STATUS;
            end else if (ev_vld_ff && !rd_data_ff.acked && expired && n_ff >= MAX_WINDOW_C) begin
               ev_vld_in = 1'b0;
               state_in  = ST_STATUS;
            end else if (!(ev_vld_ff && !rd_data_ff.acked && expired && !out_free)) begin
               if (ev_vld_ff && !rd_data_ff.acked && expired) begin
                  emit                = 1'b1;
                  emit_pl.kind        = awt_pkg::KIND_RETX;
                  emit_pl.seq         = awt_pkg::SEQ_W'(ev_idx_ff);
                  emit_pl.attempt     = rd_data_ff.retries + awt_pkg::LIMIT_W'(1);
                  mem_we              = 1'b1;
                  mem_waddr           = ev_idx_ff;
                  mem_wdata.send_time = req_ff.now_us;
                  mem_wdata.retries   = rd_data_ff.retries + awt_pkg::LIMIT_W'(1);
                  mem_wdata.resent    = 1'b1;
                  n_in                = n_ff + FW'(1);
               end
               if (rd_idx_ff < next_issue_ff) begin
                  mem_re    = 1'b1;
                  mem_raddr = rd_idx_ff[AW-1:0];
                  ev_vld_in = 1'b1;
                  ev_idx_in = rd_idx_ff[AW-1:0];
                  rd_idx_in = rd_idx_ff + CW'(1);
               end else begin
                  ev_vld_in = 1'b0;
                  if (!ev_vld_ff) begin
                     state_in = ST_STATUS;
                  end
               end
            end
         end
         ST_ACK_RD: begin
            if (req_ff.ack_seq < awt_pkg::ACK_W'(eff_total) &&
                req_ff.ack_seq < awt_pkg::ACK_W'(next_issue_ff)) begin
               mem_re    = 1'b1;
               mem_raddr = req_ff.ack_seq[AW-1:0];
               state_in  = ST_ACK_EV;
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_ACK_EV: begin
            if (rd_data_ff.acked) begin
               state_in = ST_STATUS;
            end else if (rd_data_ff.resent || out_free) begin
               mem_we          = 1'b1;
               mem_waddr       = req_ff.ack_seq[AW-1:0];
               mem_wdata       = rd_data_ff;
               mem_wdata.acked = 1'b1;
               if (flight_ff != '0) begin
                  flight_in = flight_ff - FW'(1);
               end
               if (!rd_data_ff.resent) begin
                  emit           = 1'b1;
                  emit_pl.kind   = awt_pkg::KIND_RTT;
                  emit_pl.seq    = awt_pkg::SEQ_W'(req_ff.ack_seq[AW-1:0]);
                  emit_pl.rtt_us = delta;
               end
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               emit             = 1'b1;
               emit_pl.kind     = awt_pkg::KIND_STATUS;
               emit_pl.done_res = (next_issue_ff >= eff_total) && (flight_ff == '0);
               emit_pl.aborted  = abort_ff;
               emit_pl.last     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_issue_ff <= '0;
         flight_ff     <= '0;
         n_ff          <= '0;
         abort_ff      <= 1'b0;
         rd_idx_ff     <= '0;
         ev_vld_ff     <= 1'b0;
         ev_idx_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_issue_ff <= next_issue_in;
         flight_ff     <= flight_in;
         n_ff          <= n_in;
         abort_ff      <= abort_in;
         rd_idx_ff     <= rd_idx_in;
         ev_vld_ff     <= ev_vld_in;
         ev_idx_ff     <= ev_idx_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (emit) begin
         rsp_pl_ff <= emit_pl;
      end
      if (req_if.valid && req_if.ready) begin
         req_ff <= req_if.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_total_ff   <= awt_pkg::TOTAL_RST;
         cfg_window_ff  <= awt_pkg::WINDOW_RST;
         cfg_timeout_ff <= awt_pkg::TIMEOUT_RST;
         cfg_limit_ff   <= awt_pkg::LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            awt_pkg::CSR_CHUNK_TOTAL: cfg_total_ff   <= csr_wdata[awt_pkg::TOTAL_W-1:0];
            awt_pkg::CSR_WINDOW_SIZE: cfg_window_ff  <= csr_wdata[awt_pkg::WINDOW_W-1:0];
            awt_pkg::CSR_TIMEOUT_US:  cfg_timeout_ff <= csr_wdata[awt_pkg::TIMEOUT_W-1:0];
            awt_pkg::CSR_RETRY_LIMIT: cfg_limit_ff   <= csr_wdata[awt_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   a_flight_bound: assert property (@(posedge clock) disable iff (reset)
      flight_ff <= MAX_WINDOW_C)
      else $error("flight count above window bound");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      next_issue_ff <= MAX_CHUNKS_C)
      else $error("issue pointer beyond chunk bound");

   a_abort_status: assert property (@(posedge clock) disable iff (reset)
      $rose(abort_ff) |-> state_ff == ST_STATUS)
      else $error("abort raised outside of scan end");

   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= MAX_WINDOW_C)
      else $error("too many results in one poll");

   a_scan_hazard: assert property (@(posedge clock) disable iff (reset)
      mem_we && mem_re |-> mem_waddr != mem_raddr)
      else $error("read and write to the same entry in one cycle");

endmodule

FILE: tb/sv/arq_sender_window_tracker_unit_tb.sv
// Self-checking testbench for the ARQ sender window tracker: directed table, then random
// transfers, results compared against a behavioral predictor (typed rows: fixed status).
// Depends on awt_pkg, awt_chan_if and arq_sender_window_tracker_unit.
module arq_sender_window_tracker_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit                               is_csr;
      logic [awt_pkg::CSR_INDEX_W-1:0]  csr_index;
      logic [awt_pkg::CSR_DATA_W-1:0]   csr_data;
      awt_pkg::req_payload_type         req;
      bit                               typed;
      logic                             typed_done;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [awt_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [awt_pkg::CSR_DATA_W-1:0]  csr_wdata;

   awt_chan_if #(.payload_type(awt_pkg::req_payload_type)) req_if ();
   awt_chan_if #(.payload_type(awt_pkg::rsp_payload_type)) rsp_if ();

   arq_sender_window_tracker_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // window state mirror
   logic [awt_pkg::TOTAL_W-1:0]   cfg_total;
   logic [awt_pkg::WINDOW_W-1:0]  cfg_window;
   logic [awt_pkg::TIMEOUT_W-1:0] cfg_timeout;
   logic [awt_pkg::LIMIT_W-1:0]   cfg_retry;
   int unsigned                   issue_ptr;
   int unsigned                   flight_cnt;
   bit                            chunk_sent [awt_pkg::MAX_CHUNKS_DEF];
   bit                            chunk_acked [awt_pkg::MAX_CHUNKS_DEF];
   bit                            chunk_resent [awt_pkg::MAX_CHUNKS_DEF];
   logic [awt_pkg::TIME_BITS-1:0] chunk_stamp [awt_pkg::MAX_CHUNKS_DEF];
   logic [awt_pkg::LIMIT_W-1:0]   chunk_tries [awt_pkg::MAX_CHUNKS_DEF];
   bit                            xfer_aborted;

   awt_pkg::rsp_payload_type step_q [$];
   awt_pkg::rsp_payload_type pending_rsp_q [$];
   stim_row_type             directed_rows [$];

   int error_count;
   int txn_count;
   int rsp_count;
   int retx_count;
   int rtt_count;
   int burst_left;
   int unsigned stall_tick;
   logic [awt_pkg::TIME_BITS-1:0] clock_us;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic awt_pkg::rsp_payload_type make_rsp(logic [1:0] kind, int unsigned seq,
                                                logic [awt_pkg::LIMIT_W-1:0] att,
                                                logic [awt_pkg::TIME_BITS-1:0] rtt,
                                                logic done, logic ab, logic last);
      awt_pkg::rsp_payload_type r;
      r.kind     = kind;
      r.seq      = seq[awt_pkg::SEQ_W-1:0];
      r.attempt  = att;
      r.rtt_us   = rtt;
      r.done_res = done;
      r.aborted  = ab;
      r.last     = last;
      return r;
   endfunction

   function automatic int unsigned eff_total();
      return (cfg_total > awt_pkg::MAX_CHUNKS_DEF) ? awt_pkg::MAX_CHUNKS_DEF : int'(cfg_total);
   endfunction

   function automatic logic [awt_pkg::TIMEOUT_W:0] eff_timeout();
      return (cfg_timeout == 0) ? (awt_pkg::TIMEOUT_W+1)'(1) : {1'b0, cfg_timeout};
   endfunction

   function automatic void model_csr(logic [awt_pkg::CSR_INDEX_W-1:0] idx,
                                     logic [awt_pkg::CSR_DATA_W-1:0] d);
      case (idx)
         awt_pkg::CSR_CHUNK_TOTAL: cfg_total   = d[awt_pkg::TOTAL_W-1:0];
         awt_pkg::CSR_WINDOW_SIZE: cfg_window  = d[awt_pkg::WINDOW_W-1:0];
         awt_pkg::CSR_TIMEOUT_US:  cfg_timeout = d[awt_pkg::TIMEOUT_W-1:0];
         awt_pkg::CSR_RETRY_LIMIT: cfg_retry   = d[awt_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void predict_transaction(awt_pkg::req_payload_type r);
      int unsigned total;
      int unsigned win;
      int unsigned n;
      int unsigned s;
      logic [awt_pkg::TIME_BITS-1:0] age;
      total = eff_total();
      n = 0;
      step_q.delete();
      if (!xfer_aborted) begin
         if (r.req_type == awt_pkg::REQ_POLL) begin
            win = (cfg_window == 0) ? 1 :
                  ((cfg_window > awt_pkg::MAX_WINDOW_DEF) ? awt_pkg::MAX_WINDOW_DEF
                                                          : cfg_window);
            while (issue_ptr < total && flight_cnt < win && n < awt_pkg::MAX_WINDOW_DEF) begin
               s = issue_ptr;
               chunk_sent[s]   = 1'b1;
               chunk_acked[s]  = 1'b0;
               chunk_resent[s] = 1'b0;
               chunk_stamp[s]  = r.now_us;
               chunk_tries[s]  = '0;
               flight_cnt++;
               issue_ptr++;
               step_q = {step_q,
                         make_rsp(awt_pkg::KIND_SEND, s, '0, '0, 1'b0, 1'b0, 1'b0)};
               n++;
            end
            for (int unsigned i = 0; i < issue_ptr && i < awt_pkg::MAX_CHUNKS_DEF; i++) begin
               if (!chunk_sent[i] || chunk_acked[i]) continue;
               age = r.now_us - chunk_stamp[i];
               if (age < eff_timeout()) continue;
               if (chunk_tries[i] >= cfg_retry) begin
                  xfer_aborted = 1'b1;
                  break;
               end
               if (n >= awt_pkg::MAX_WINDOW_DEF) break;
               chunk_stamp[i]  = r.now_us;
               chunk_resent[i] = 1'b1;
               chunk_tries[i]  = chunk_tries[i] + 1'b1;
               step_q = {step_q, make_rsp(awt_pkg::KIND_RETX, i, chunk_tries[i], '0,
                                          1'b0, 1'b0, 1'b0)};
               retx_count++;
               n++;
            end
         end else if (r.ack_seq < total && chunk_sent[r.ack_seq] && !chunk_acked[r.ack_seq])
         begin
            s = r.ack_seq;
            chunk_acked[s] = 1'b1;
            if (flight_cnt > 0) flight_cnt--;
            if (!chunk_resent[s]) begin
               step_q = {step_q, make_rsp(awt_pkg::KIND_RTT, s, '0, r.now_us - chunk_stamp[s],
                                          1'b0, 1'b0, 1'b0)};
               rtt_count++;
            end
         end
      end
      step_q = {step_q, make_rsp(awt_pkg::KIND_STATUS, 0, '0, '0,
                                 (issue_ptr >= total && flight_cnt == 0), xfer_aborted, 1'b1)};
   endfunction

   task automatic wait_quiet();
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [awt_pkg::CSR_INDEX_W-1:0] idx,
                            logic [awt_pkg::CSR_DATA_W-1:0] d);
      req_if.valid = 1'b0;
      wait_quiet();
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = d;
      model_csr(idx, d);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // present one transaction; expectations are queued before valid rises
   task automatic send_req(awt_pkg::req_payload_type r, bit typed, logic typed_done);
      if (burst_left == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      predict_transaction(r);
      if (typed)
         pending_rsp_q = {pending_rsp_q, make_rsp(awt_pkg::KIND_STATUS, 0, '0, '0,
                                                  typed_done, 1'b0, 1'b1)};
      else
         pending_rsp_q = {pending_rsp_q, step_q};
      req_if.valid   = 1'b1;
      req_if.payload = r;
      do @(posedge clock); while (!req_if.ready);
      txn_count++;
      burst_left--;
      @(negedge clock);
   endtask

   function automatic awt_pkg::req_payload_type mk_req(logic typ,
                                                       logic [awt_pkg::TIME_BITS-1:0] now,
                                                       logic [awt_pkg::ACK_W-1:0] seq);
      awt_pkg::req_payload_type r;
      r.req_type = typ;
      r.now_us   = now;
      r.ack_seq  = seq;
      return r;
   endfunction

   function automatic void add_row(bit is_csr, logic [awt_pkg::CSR_INDEX_W-1:0] idx,
                                   logic [awt_pkg::CSR_DATA_W-1:0] d,
                                   awt_pkg::req_payload_type r,
                                   bit typed, logic typed_done);
      stim_row_type row;
      row.is_csr     = is_csr;
      row.csr_index  = idx;
      row.csr_data   = d;
      row.req        = r;
      row.typed      = typed;
      row.typed_done = typed_done;
      directed_rows = {directed_rows, row};
   endfunction

   task automatic random_txn();
      int unsigned pick;
      int unsigned open_list [$];
      logic [awt_pkg::TIMEOUT_W:0] tmo;
      tmo  = eff_timeout();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         clock_us = clock_us + $urandom_range(0, 2 * tmo);
         send_req(mk_req(awt_pkg::REQ_POLL, clock_us, $urandom), 1'b0, 1'b0);
      end else if (pick < 85) begin
         for (int unsigned i = 0; i < issue_ptr; i++)
            if (chunk_sent[i] && !chunk_acked[i]) open_list = {open_list, i};
         clock_us = clock_us + $urandom_range(0, tmo);
         if (open_list.size() != 0)
            send_req(mk_req(awt_pkg::REQ_ACK, clock_us,
                            open_list[$urandom_range(0, open_list.size()-1)]),
                     1'b0, 1'b0);
         else
            send_req(mk_req(awt_pkg::REQ_POLL, clock_us, '0), 1'b0, 1'b0);
      end else if (pick < 95) begin
         send_req(mk_req(awt_pkg::REQ_ACK, clock_us,
                         ($urandom_range(0, 1) != 0) ? $urandom
                                                     : $urandom_range(0, issue_ptr + 3)),
                  1'b0, 1'b0);
      end else begin
         clock_us = awt_pkg::TIME_BITS'({$urandom, $urandom});
         send_req(mk_req(awt_pkg::REQ_POLL, clock_us, $urandom), 1'b0, 1'b0);
      end
   endtask

   // receiver: always-ready, coin-flip and long-stall stretches
   always @(negedge clock) begin
      stall_tick++;
      case ((stall_tick / 700) % 3)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= 1'($urandom_range(0, 1));
         default: rsp_if.ready <= ((stall_tick % 24) < 6);
      endcase
   end

   always @(posedge clock) begin
      awt_pkg::rsp_payload_type got;
      awt_pkg::rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         rsp_count++;
         if (pending_rsp_q.size() == 0) begin
            $error("unexpected result kind=%0d seq=%0d", got.kind, got.seq);
            error_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (got.kind !== want.kind) begin
               $error("kind: expected %0d actual %0d", want.kind, got.kind);
               error_count++;
            end
            if (got.seq !== want.seq) begin
               $error("seq: expected %0d actual %0d", want.seq, got.seq);
               error_count++;
            end
            if (got.attempt !== want.attempt) begin
               $error("attempt: expected %0d actual %0d", want.attempt, got.attempt);
               error_count++;
            end
            if (got.rtt_us !== want.rtt_us) begin
               $error("rtt_us: expected %0d actual %0d", want.rtt_us, got.rtt_us);
               error_count++;
            end
            if (got.done_res !== want.done_res) begin
               $error("done_res: expected %0d actual %0d", want.done_res, got.done_res);
               error_count++;
            end
            if (got.aborted !== want.aborted) begin
               $error("aborted: expected %0d actual %0d", want.aborted, got.aborted);
               error_count++;
            end
            if (got.last !== want.last) begin
               $error("last: expected %0d actual %0d", want.last, got.last);
               error_count++;
            end
         end
      end
   end

   initial begin
      int unsigned total_pick;
      int unsigned waited;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b1;
      csr_we         = 1'b0;
      csr_index      = awt_pkg::CSR_CHUNK_TOTAL;
      csr_wdata      = '0;
      reset          = 1'b1;
      cfg_total      = awt_pkg::TOTAL_RST;
      cfg_window     = awt_pkg::WINDOW_RST;
      cfg_timeout    = awt_pkg::TIMEOUT_RST;
      cfg_retry      = awt_pkg::LIMIT_RST;
      issue_ptr      = 0;
      flight_cnt     = 0;
      xfer_aborted   = 1'b0;
      error_count    = 0;
      txn_count      = 0;
      rsp_count      = 0;
      retx_count     = 0;
      rtt_count      = 0;
      burst_left     = 0;
      stall_tick     = 0;
      foreach (chunk_sent[i]) begin
         chunk_sent[i]   = 1'b0;
         chunk_acked[i]  = 1'b0;
         chunk_resent[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // after reset: empty transfer is done, bad ack ignored
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_POLL, 48'd0, 32'd0), 1, 1'b1);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_ACK, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF), 1, 1'b1);
      // tiny window, zero timeout, max retry limit
      add_row(1, awt_pkg::CSR_CHUNK_TOTAL, 24'd3, '0, 0, 1'b0);
      add_row(1, awt_pkg::CSR_WINDOW_SIZE, 24'd0, '0, 0, 1'b0);
      add_row(1, awt_pkg::CSR_TIMEOUT_US, 24'd0, '0, 0, 1'b0);
      add_row(1, awt_pkg::CSR_RETRY_LIMIT, 24'd255, '0, 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_POLL, 48'd100, 32'd0), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_POLL, 48'd100, 32'd0), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_POLL, 48'd101, 32'd0), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_ACK, 48'd105, 32'd0), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_ACK, 48'd106, 32'd0), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_POLL, 48'd200, 32'd0), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_ACK, 48'd250, 32'd1), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_POLL, 48'hFFFF_FFFF_FFF0, 32'd0), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_ACK, 48'd3, 32'd3), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_ACK, 48'd5, 32'd2), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_POLL, 48'd9, 32'd0), 0, 1'b0);
      // oversized count and window, max timeout
      add_row(1, awt_pkg::CSR_CHUNK_TOTAL, 24'd8191, '0, 0, 1'b0);
      add_row(1, awt_pkg::CSR_WINDOW_SIZE, 24'd63, '0, 0, 1'b0);
      add_row(1, awt_pkg::CSR_TIMEOUT_US, 24'hFF_FFFF, '0, 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_POLL, 48'd0, 32'd0), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_POLL, 48'hFFFF_FFFF_FFFF, 32'd0), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_ACK, 48'd10, 32'd4096), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_ACK, 48'd20, 32'd5), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_POLL, 48'd1000, 32'd0), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_ACK, 48'd2000, 32'd35), 0, 1'b0);
      add_row(0, '0, '0, mk_req(awt_pkg::REQ_ACK, 48'd2500, 32'd32), 0, 1'b0);

      foreach (directed_rows[k]) begin
         if (directed_rows[k].is_csr)
            write_csr(directed_rows[k].csr_index, directed_rows[k].csr_data);
         else
            send_req(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].typed_done);
      end
      clock_us = 48'd5000;

      // random transfers; a large retry limit keeps the abort for the end
      for (int phase = 0; phase < 8; phase++) begin
         write_csr(awt_pkg::CSR_RETRY_LIMIT, awt_pkg::CSR_DATA_W'($urandom_range(200, 255)));
         case (phase % 4)
            0: total_pick = issue_ptr + $urandom_range(5, 40);
            1: total_pick = (issue_ptr > 4) ? issue_ptr - 3 : 0;
            2: total_pick = issue_ptr + $urandom_range(0, 10);
            default: total_pick = issue_ptr + $urandom_range(1, 60);
         endcase
         if (total_pick > awt_pkg::MAX_CHUNKS_DEF) total_pick = awt_pkg::MAX_CHUNKS_DEF;
         write_csr(awt_pkg::CSR_CHUNK_TOTAL, awt_pkg::CSR_DATA_W'(total_pick));
         write_csr(awt_pkg::CSR_WINDOW_SIZE,
                   awt_pkg::CSR_DATA_W'((phase == 3) ? 32 : $urandom_range(0, 63)));
         write_csr(awt_pkg::CSR_TIMEOUT_US,
                   awt_pkg::CSR_DATA_W'((phase == 5) ? 0 : $urandom_range(1, 60)));
         for (int j = 0; j < 15; j++) begin
            if (j == 9) begin
               req_if.valid = 1'b0;
               while (pending_rsp_q.size() != 0) @(negedge clock);
            end
            random_txn();
         end
      end

      // retry exhaustion, then the sticky abort
      write_csr(awt_pkg::CSR_RETRY_LIMIT, 24'd0);
      write_csr(awt_pkg::CSR_TIMEOUT_US, 24'd1);
      write_csr(awt_pkg::CSR_CHUNK_TOTAL,
                awt_pkg::CSR_DATA_W'((issue_ptr + 2 > awt_pkg::MAX_CHUNKS_DEF) ?
                                     awt_pkg::MAX_CHUNKS_DEF : issue_ptr + 2));
      send_req(mk_req(awt_pkg::REQ_POLL, clock_us, '0), 1'b0, 1'b0);
      send_req(mk_req(awt_pkg::REQ_POLL, clock_us + 10, '0), 1'b0, 1'b0);
      send_req(mk_req(awt_pkg::REQ_ACK, clock_us + 11, issue_ptr - 1), 1'b0, 1'b0);
      send_req(mk_req(awt_pkg::REQ_POLL, clock_us + 500, '0), 1'b0, 1'b0);
      req_if.valid = 1'b0;

      waited = 0;
      while (pending_rsp_q.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (50) @(posedge clock);
      if (pending_rsp_q.size() != 0) begin
         $error("%0d expected results never arrived", pending_rsp_q.size());
         error_count++;
      end
      $display("Covered %0d transactions and %0d results (%0d retransmits, %0d rtt samples),",
               txn_count, rsp_count, retx_count, rtt_count);
      $display("config extremes, clamped count/window, time wrap and sticky abort=%0d.",
               xfer_aborted);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
